// ===== src/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared widths, command codes and the step record for the circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int RAD_BITS    = COORD_BITS - 1;
	localparam int OUT_BITS    = COORD_BITS + 1;
	localparam int XOFF_BITS   = COORD_BITS + 1;
	localparam int YOFF_BITS   = COORD_BITS;
	localparam int ERR_BITS    = COORD_BITS + 3;
	localparam int PT_PER_STEP = 8;
	localparam int IDX_BITS    = $clog2(PT_PER_STEP);

	localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(PT_PER_STEP - 1);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	// one octant position, handed from the step engine to the point emitter
	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [RAD_BITS-1:0]          x;
		logic [RAD_BITS-1:0]          y;
		logic                         fin;
	} snap_t;

endpackage

// ===== src/mcr_step.sv =====
// ----------------------------------------------------------------------------
// mcr_step
// Request register and midpoint iteration state. Each accepted step of a circle
// in progress yields one octant position for the emitter and advances x, y and the error term.
// ----------------------------------------------------------------------------
module mcr_step import mcr_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         cmd,
	input  logic signed [COORD_BITS-1:0] ctr_x,
	input  logic signed [COORD_BITS-1:0] ctr_y,
	input  logic [RAD_BITS-1:0]          radius,
	output logic                         snap_valid,
	input  logic                         snap_ready,
	output snap_t                        snap
);

	logic                         valid_s1;
	cmd_t                         cmd_s1;
	logic signed [COORD_BITS-1:0] cx_s1;
	logic signed [COORD_BITS-1:0] cy_s1;
	logic [RAD_BITS-1:0]          rad_s1;

	logic signed [COORD_BITS-1:0] cx_q;
	logic signed [COORD_BITS-1:0] cy_q;
	logic signed [XOFF_BITS-1:0]  xoff_q;
	logic [YOFF_BITS-1:0]         yoff_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic                         active_q;

	logic                         emit_now;
	logic                         consume;
	logic [YOFF_BITS-1:0]         y1;
	logic signed [ERR_BITS-1:0]   y1_odd;
	logic signed [ERR_BITS-1:0]   e1;
	logic                         dec;
	logic signed [XOFF_BITS-1:0]  x1;
	logic signed [ERR_BITS-1:0]   x1_odd;
	logic signed [ERR_BITS-1:0]   e2;
	logic                         fin;

	assign emit_now  = valid_s1 && (cmd_s1 == CMD_STEP) && active_q &&
		(xoff_q >= $signed({1'b0, yoff_q}));
	assign consume   = valid_s1 && (!emit_now || snap_ready);
	assign req_stall = valid_s1 && !consume;

	// midpoint update
	always_comb begin
		y1     = yoff_q + YOFF_BITS'(1);
		y1_odd = $signed({{(ERR_BITS - YOFF_BITS - 1){1'b0}}, y1, 1'b1});
		e1     = (err_q <= 0) ? err_q + y1_odd : err_q;
		dec    = (e1 > 0);
		x1     = dec ? xoff_q - XOFF_BITS'(1) : xoff_q;
		x1_odd = $signed({{(ERR_BITS - XOFF_BITS - 1){x1[XOFF_BITS-1]}}, x1, 1'b1});
		e2     = dec ? e1 - x1_odd : e1;
		fin    = (x1 < $signed({1'b0, y1}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1 <= cmd_t'(cmd);
			cx_s1  <= ctr_x;
			cy_s1  <= ctr_y;
			rad_s1 <= radius;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			xoff_q   <= '0;
			yoff_q   <= '0;
			err_q    <= '0;
			active_q <= 1'b0;
		end else if (consume) begin
			if (cmd_s1 == CMD_START) begin
				cx_q     <= cx_s1;
				cy_q     <= cy_s1;
				xoff_q   <= $signed({{(XOFF_BITS - RAD_BITS){1'b0}}, rad_s1});
				yoff_q   <= '0;
				err_q    <= '0;
				active_q <= 1'b1;
			end else if (emit_now) begin
				xoff_q   <= x1;
				yoff_q   <= y1;
				err_q    <= e2;
				active_q <= !fin;
			end else begin
				active_q <= 1'b0;
			end
		end
	end

	assign snap_valid = emit_now;
	assign snap.cx    = cx_q;
	assign snap.cy    = cy_q;
	assign snap.x     = xoff_q[RAD_BITS-1:0];
	assign snap.y     = yoff_q[RAD_BITS-1:0];
	assign snap.fin   = fin;

	a_fin_clears_active: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_now && snap_ready && fin) |=> !active_q)
		else $error("active still set after final step");

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && cmd_s1 == CMD_START) |=> (active_q && yoff_q == '0))
		else $error("start did not prime the iteration");

	a_idle_no_snap: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> !snap_valid)
		else $error("step emitted with no circle in progress");

endmodule

// ===== src/mcr_emit.sv =====
// ----------------------------------------------------------------------------
// mcr_emit
// Holds one octant position and serialises its eight mirrored points,
// one per cycle while pt_stall is low, flagging the final point of the circle.
// ----------------------------------------------------------------------------
module mcr_emit import mcr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       snap_valid,
	output logic                       snap_ready,
	input  snap_t                      snap,
	output logic                       pt_valid,
	input  logic                       pt_stall,
	output logic signed [OUT_BITS-1:0] point_x,
	output logic signed [OUT_BITS-1:0] point_y,
	output logic                       last
);

	logic                       busy_q;
	logic [IDX_BITS-1:0]        idx_q;
	snap_t                      snap_q;

	logic                       fire;
	logic                       done;
	logic                       load;
	logic                       swap;
	logic                       neg_x;
	logic                       neg_y;
	logic [RAD_BITS-1:0]        a;
	logic [RAD_BITS-1:0]        b;
	logic signed [OUT_BITS-1:0] a_ext;
	logic signed [OUT_BITS-1:0] b_ext;
	logic signed [OUT_BITS-1:0] cx_ext;
	logic signed [OUT_BITS-1:0] cy_ext;

	assign fire       = busy_q && !pt_stall;
	assign done       = fire && (idx_q == IDX_LAST);
	assign snap_ready = !busy_q || done;
	assign load       = snap_valid && snap_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			idx_q <= idx_q + IDX_BITS'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			snap_q <= snap;
		end
	end

	// point order decoded from the index bits:
	// x and y swap on 1,2,5,6; column negated on 2..5; row negated on 4..7
	always_comb begin
		swap   = idx_q[0] ^ idx_q[1];
		neg_x  = idx_q[1] ^ idx_q[2];
		neg_y  = idx_q[2];
		a      = swap ? snap_q.y : snap_q.x;
		b      = swap ? snap_q.x : snap_q.y;
		a_ext  = $signed({{(OUT_BITS - RAD_BITS){1'b0}}, a});
		b_ext  = $signed({{(OUT_BITS - RAD_BITS){1'b0}}, b});
		cx_ext = $signed({snap_q.cx[COORD_BITS-1], snap_q.cx});
		cy_ext = $signed({snap_q.cy[COORD_BITS-1], snap_q.cy});
	end

	assign point_x  = neg_x ? cx_ext - a_ext : cx_ext + a_ext;
	assign point_y  = neg_y ? cy_ext - b_ext : cy_ext + b_ext;
	assign last     = busy_q && (idx_q == IDX_LAST) && snap_q.fin;
	assign pt_valid = busy_q;

	a_load_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(load && busy_q) |-> (idx_q == IDX_LAST && !pt_stall))
		else $error("new position loaded over points still owed");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && last) |-> (idx_q == IDX_LAST))
		else $error("last flagged before the eighth point");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !snap_valid) |=> !busy_q)
		else $error("emitter still busy after eighth point");

endmodule

// ===== src/midpoint_circle_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top
// Integer midpoint circle outline generator: start loads centre and radius,
// each step of a circle in progress gives the eight mirrored points of one octant position.
//
//   channel   handshake             payload
//   request   req_valid/req_stall   cmd, ctr_x, ctr_y, radius
//   point     pt_valid/pt_stall     point_x, point_y, last
//
// a step request gives eight points, one per cycle from the point emitter while pt_stall is low,
// so in a run of steps each request waits in the request register until the emitter is free
// start requests and steps with no circle in progress give no points and never wait on the emitter
// an accepted request is held in the request register, from which the iteration takes it
// reset clears the iteration state; no circle is in progress afterwards
// point stalls back up into the request channel once the request register
// holds a step that the emitter cannot yet take
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_top import mcr_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         cmd,
	input  logic signed [COORD_BITS-1:0] ctr_x,
	input  logic signed [COORD_BITS-1:0] ctr_y,
	input  logic [RAD_BITS-1:0]          radius,
	output logic                         pt_valid,
	input  logic                         pt_stall,
	output logic signed [OUT_BITS-1:0]   point_x,
	output logic signed [OUT_BITS-1:0]   point_y,
	output logic                         last
);

	logic  snap_valid;
	logic  snap_ready;
	snap_t snap;

	mcr_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.ctr_x      (ctr_x),
		.ctr_y      (ctr_y),
		.radius     (radius),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	mcr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.pt_valid   (pt_valid),
		.pt_stall   (pt_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.last       (last)
	);

endmodule

// ===== tb/tb_midpoint_circle_rasterizer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midpoint_circle_rasterizer_top
// Drives start and step requests into the circle rasterizer, predicts every
// outline point from its own midpoint iteration and checks each point in order.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_rasterizer_top;
	import mcr_pkg::*;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] px;
		logic signed [OUT_BITS-1:0] py;
		logic                       lst;
	} outline_pt_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         req_valid;
	logic                         req_stall;
	logic                         cmd;
	logic signed [COORD_BITS-1:0] ctr_x;
	logic signed [COORD_BITS-1:0] ctr_y;
	logic [RAD_BITS-1:0]          radius;
	logic                         pt_valid;
	logic                         pt_stall;
	logic signed [OUT_BITS-1:0]   point_x;
	logic signed [OUT_BITS-1:0]   point_y;
	logic                         last;

	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          hold_off;
	int          fail_count;
	int          live_items;
	outline_pt_t pending_pts[$];
	outline_pt_t want;

	// predicted iteration state
	logic signed [COORD_BITS-1:0] circ_cx;
	logic signed [COORD_BITS-1:0] circ_cy;
	int                           circ_x;
	int                           circ_y;
	int                           circ_err;
	bit                           circle_live;

	always #1 clk = ~clk;

	midpoint_circle_rasterizer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.ctr_x     (ctr_x),
		.ctr_y     (ctr_y),
		.radius    (radius),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.last      (last)
	);

	function automatic void push_point(int px, int py, bit lst);
		outline_pt_t p;
		p.px = px[OUT_BITS-1:0];
		p.py = py[OUT_BITS-1:0];
		p.lst = lst;
		pending_pts.push_back(p);
	endfunction

	// returns the number of points the request produces
	function automatic int advance_circle(cmd_t c, logic signed [COORD_BITS-1:0] nx,
			logic signed [COORD_BITS-1:0] ny, logic [RAD_BITS-1:0] nr);
		int x;
		int y;
		int ox;
		int oy;
		bit fin;
		if (c == CMD_START) begin
			circ_cx = nx;
			circ_cy = ny;
			circ_x = nr;
			circ_y = 0;
			circ_err = 0;
			circle_live = 1'b1;
			return 0;
		end
		if (!circle_live || circ_x < circ_y) begin
			circle_live = 1'b0;
			return 0;
		end
		x = circ_x;
		y = circ_y;
		ox = circ_cx;
		oy = circ_cy;
		circ_y++;
		if (circ_err <= 0)
			circ_err += 2 * circ_y + 1;
		if (circ_err > 0) begin
			circ_x--;
			circ_err -= 2 * circ_x + 1;
		end
		fin = circ_x < circ_y;
		if (fin)
			circle_live = 1'b0;
		push_point(ox + x, oy + y, 1'b0);
		push_point(ox + y, oy + x, 1'b0);
		push_point(ox - y, oy + x, 1'b0);
		push_point(ox - x, oy + y, 1'b0);
		push_point(ox - x, oy - y, 1'b0);
		push_point(ox - y, oy - x, 1'b0);
		push_point(ox + y, oy - x, 1'b0);
		push_point(ox + x, oy - y, fin);
		return PT_PER_STEP;
	endfunction

	task automatic send_request(cmd_t c, logic signed [COORD_BITS-1:0] nx,
			logic signed [COORD_BITS-1:0] ny, logic [RAD_BITS-1:0] nr);
		bit taken;
		int n_pts;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		cmd <= c;
		ctr_x <= nx;
		ctr_y <= ny;
		radius <= nr;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !req_stall;
		end
		n_pts = advance_circle(c, nx, ny, nr);
		if (c == CMD_START || n_pts != 0)
			live_items++;
	endtask

	// step payload fields are unused, so they carry noise
	task automatic send_step();
		send_request(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
			RAD_BITS'($urandom));
	endtask

	task automatic run_circle(logic signed [COORD_BITS-1:0] nx,
			logic signed [COORD_BITS-1:0] ny, logic [RAD_BITS-1:0] nr,
			int max_steps, int extra);
		int k;
		send_request(CMD_START, nx, ny, nr);
		k = 0;
		while (circle_live && k < max_steps) begin
			send_step();
			k++;
		end
		repeat (extra) send_step();
	endtask

	task automatic settle_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_pts.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		tx_idle_pct = 8;
		rx_idle_pct = 69;
		// step with nothing in progress straight after reset
		send_step();
		// zero radius: eight points on the centre, then a step after completion
		run_circle(COORD_BITS'(-2048), COORD_BITS'(2047), RAD_BITS'(0), 1000, 1);
		run_circle(COORD_BITS'(2047), COORD_BITS'(-2048), RAD_BITS'(2047), 3, 0);
		run_circle(COORD_BITS'(-2048), COORD_BITS'(-2048), RAD_BITS'(1), 1000, 1);
		// a start overridden by another start before any step
		send_request(CMD_START, COORD_BITS'(-2048), COORD_BITS'(2047), RAD_BITS'(2047));
		run_circle(COORD_BITS'(2047), COORD_BITS'(2047), RAD_BITS'(2047), 2, 0);
		run_circle(COORD_BITS'(0), COORD_BITS'(0), RAD_BITS'(5), 1000, 1);
		settle_idle();
	endtask

	task automatic test_random_circles(int tx, int rx, int n_items);
		int goal;
		int kind;
		int steps;
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		goal = live_items + n_items;
		while (live_items < goal) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				send_step();
			end else if (kind < 3) begin
				// random radius over the full range, given at most six steps
				run_circle(COORD_BITS'($urandom), COORD_BITS'($urandom),
					RAD_BITS'($urandom), $urandom_range(1, 6), 0);
			end else begin
				steps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 1000;
				run_circle(COORD_BITS'($urandom), COORD_BITS'($urandom),
					RAD_BITS'($urandom_range(0, 12)), steps,
					($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
			end
		end
		settle_idle();
	endtask

	task automatic test_point_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			run_circle(COORD_BITS'(100), COORD_BITS'(-100), RAD_BITS'(40), 12, 0);
		join
		settle_idle();
	endtask

	always @(negedge clk)
		pt_stall <= hold_off || ($urandom_range(0, 99) < rx_idle_pct);

	always @(posedge clk) begin
		if (arst_n && pt_valid && !pt_stall) begin
			if (pending_pts.size() == 0) begin
				$error("unexpected point: point_x %0d point_y %0d last %0b",
					point_x, point_y, last);
				fail_count++;
			end else begin
				want = pending_pts.pop_front();
				if (point_x !== want.px) begin
					$error("point_x: expected %0d, got %0d", want.px, point_x);
					fail_count++;
				end
				if (point_y !== want.py) begin
					$error("point_y: expected %0d, got %0d", want.py, point_y);
					fail_count++;
				end
				if (last !== want.lst) begin
					$error("last: expected %0b, got %0b", want.lst, last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("tb_midpoint_circle_rasterizer_top failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		cmd = CMD_STEP;
		ctr_x = '0;
		ctr_y = '0;
		radius = '0;
		pt_stall = 1'b0;
		hold_off = 1'b0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		fail_count = 0;
		live_items = 0;
		circ_cx = '0;
		circ_cy = '0;
		circ_x = 0;
		circ_y = 0;
		circ_err = 0;
		circle_live = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_circles(8, 69, 58);
		test_random_circles(69, 8, 58);
		test_random_circles(0, 0, 58);
		test_point_backpressure();

		// let any stray points surface before the verdict
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_midpoint_circle_rasterizer_top passed");
		end else begin
			$display("tb_midpoint_circle_rasterizer_top failed");
		end
		$finish;
	end

endmodule
